>>> src/cbpg_pkg.sv
// Shared constants and types of the cubic Bezier point generator.
`timescale 1ns / 1ps
`default_nettype none
package cbpg_pkg;

  localparam int STEPS       = 100;
  localparam int T_FRAC_BITS = 16;

  localparam int COORD_W   = 16;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;

  localparam int K_W    = $clog2(STEPS);
  localparam int R_W    = $clog2(2 * STEPS);
  localparam int T_INC  = (2 ** T_FRAC_BITS) / STEPS;
  localparam int T_REM  = (2 ** T_FRAC_BITS) % STEPS;
  localparam int R_INIT = STEPS / 2;

  localparam int MA_W   = (T_FRAC_BITS + 2 > COORD_W) ? T_FRAC_BITS + 2 : COORD_W;
  localparam int MB_W   = T_FRAC_BITS + 3;
  localparam int PW     = MA_W + MB_W;
  localparam int SW     = PW + 2;
  localparam int W_HALF = 2 ** (T_FRAC_BITS - 1);

  typedef logic [NUM_REGS-1:0][COORD_W-1:0] ctrl_regs_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef enum logic [3:0] {
    OP_UU    = 4'd0,
    OP_TT    = 4'd1,
    OP_W0    = 4'd2,
    OP_W1    = 4'd3,
    OP_W2    = 4'd4,
    OP_W3    = 4'd5,
    OP_X0    = 4'd6,
    OP_Y0    = 4'd7,
    OP_X1    = 4'd8,
    OP_Y1    = 4'd9,
    OP_X2    = 4'd10,
    OP_Y2    = 4'd11,
    OP_X3    = 4'd12,
    OP_Y3    = 4'd13,
    OP_DRAIN = 4'd14
  } op_t;

  typedef struct packed {
    logic run;
    op_t  op;
  } dp_ctl_t;

  typedef struct packed {
    logic clear;
    logic step;
  } tgen_ctl_t;

endpackage
`default_nettype wire

>>> src/cbpg_tgen.sv
// Step counter and incremental t = round(k * 2^F / STEPS) generator.
`timescale 1ns / 1ps
`default_nettype none
module cbpg_tgen (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cbpg_pkg::tgen_ctl_t               ctl,
  output logic [cbpg_pkg::T_FRAC_BITS-1:0]  t_val,
  output logic                              at_last
);

  logic [cbpg_pkg::K_W-1:0]         k_r, k_nxt;
  logic [cbpg_pkg::T_FRAC_BITS-1:0] q_r, q_nxt;
  logic [cbpg_pkg::R_W-1:0]         r_r, r_nxt;
  logic [cbpg_pkg::R_W-1:0]         r_sum;
  logic                             carry;

  assign at_last = (k_r == cbpg_pkg::K_W'(cbpg_pkg::STEPS - 1));
  assign t_val   = q_r;

  always_comb begin
    r_sum = r_r + cbpg_pkg::R_W'(cbpg_pkg::T_REM);
    carry = (r_sum >= cbpg_pkg::R_W'(cbpg_pkg::STEPS));
    k_nxt = k_r;
    q_nxt = q_r;
    r_nxt = r_r;
    if (ctl.clear || (ctl.step && at_last)) begin
      k_nxt = '0;
      q_nxt = '0;
      r_nxt = cbpg_pkg::R_W'(cbpg_pkg::R_INIT);
    end else if (ctl.step) begin
      k_nxt = k_r + cbpg_pkg::K_W'(1);
      q_nxt = q_r + cbpg_pkg::T_FRAC_BITS'(cbpg_pkg::T_INC)
            + cbpg_pkg::T_FRAC_BITS'(carry);
      r_nxt = carry ? (r_sum - cbpg_pkg::R_W'(cbpg_pkg::STEPS)) : r_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      q_r <= '0;
      r_r <= cbpg_pkg::R_W'(cbpg_pkg::R_INIT);
    end else begin
      k_r <= k_nxt;
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/cbpg_dpath.sv
// Shared multiplier, Bernstein weight registers and coordinate accumulators.
`timescale 1ns / 1ps
`default_nettype none
module cbpg_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cbpg_pkg::dp_ctl_t                 ctl,
  input  logic [cbpg_pkg::T_FRAC_BITS-1:0]  t_val,
  input  cbpg_pkg::ctrl_regs_t              ctrl,
  output logic signed [15:0]                x_coord,
  output logic signed [15:0]                y_coord
);

  localparam int F  = cbpg_pkg::T_FRAC_BITS;
  localparam int RW = cbpg_pkg::SW - cbpg_pkg::T_FRAC_BITS;

  logic [F:0]                          u_val, t_ext;
  logic [F:0]                          u2_r, t2_r;
  logic [F+1:0]                        w0_r, w1_r, w2_r, w3_r;
  logic signed [cbpg_pkg::MA_W-1:0]    ma;
  logic signed [cbpg_pkg::MB_W-1:0]    mb;
  logic signed [cbpg_pkg::PW-1:0]      prod_nxt, prod_r;
  cbpg_pkg::op_t                       pop_r;
  logic                                pvld_r;
  logic [cbpg_pkg::PW-1:0]             wsum;
  logic [F:0]                          wrnd;
  logic [F+1:0]                        wrnd3;
  logic signed [cbpg_pkg::SW-1:0]      pext;
  logic signed [cbpg_pkg::SW-1:0]      accx_r, accy_r;

  function automatic logic signed [15:0] sat_round(input logic signed [cbpg_pkg::SW-1:0] a);
    logic signed [cbpg_pkg::SW-1:0] v;
    logic signed [RW-1:0]           r;
    logic signed [15:0]             res;
    v = a + cbpg_pkg::SW'(cbpg_pkg::W_HALF);
    r = RW'(v >>> F);
    if (!r[RW-1] && (|r[RW-2:15])) begin
      res = 16'sh7fff;
    end else if (r[RW-1] && !(&r[RW-2:15])) begin
      res = 16'sh8000;
    end else begin
      res = r[15:0];
    end
    return res;
  endfunction

  assign t_ext = {1'b0, t_val};
  assign u_val = {1'b1, F'(0)} - t_ext;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (ctl.op)
      cbpg_pkg::OP_UU: begin
        ma = cbpg_pkg::MA_W'(u_val);
        mb = cbpg_pkg::MB_W'(u_val);
      end
      cbpg_pkg::OP_TT: begin
        ma = cbpg_pkg::MA_W'(t_ext);
        mb = cbpg_pkg::MB_W'(t_ext);
      end
      cbpg_pkg::OP_W0: begin
        ma = cbpg_pkg::MA_W'(u2_r);
        mb = cbpg_pkg::MB_W'(u_val);
      end
      cbpg_pkg::OP_W1: begin
        ma = cbpg_pkg::MA_W'(u2_r);
        mb = cbpg_pkg::MB_W'(t_ext);
      end
      cbpg_pkg::OP_W2: begin
        ma = cbpg_pkg::MA_W'(u_val);
        mb = cbpg_pkg::MB_W'(t2_r);
      end
      cbpg_pkg::OP_W3: begin
        ma = cbpg_pkg::MA_W'(t2_r);
        mb = cbpg_pkg::MB_W'(t_ext);
      end
      cbpg_pkg::OP_X0: begin
        ma = cbpg_pkg::MA_W'($signed(ctrl[0]));
        mb = cbpg_pkg::MB_W'(w0_r);
      end
      cbpg_pkg::OP_Y0: begin
        ma = cbpg_pkg::MA_W'($signed(ctrl[1]));
        mb = cbpg_pkg::MB_W'(w0_r);
      end
      cbpg_pkg::OP_X1: begin
        ma = cbpg_pkg::MA_W'($signed(ctrl[2]));
        mb = cbpg_pkg::MB_W'(w1_r);
      end
      cbpg_pkg::OP_Y1: begin
        ma = cbpg_pkg::MA_W'($signed(ctrl[3]));
        mb = cbpg_pkg::MB_W'(w1_r);
      end
      cbpg_pkg::OP_X2: begin
        ma = cbpg_pkg::MA_W'($signed(ctrl[4]));
        mb = cbpg_pkg::MB_W'(w2_r);
      end
      cbpg_pkg::OP_Y2: begin
        ma = cbpg_pkg::MA_W'($signed(ctrl[5]));
        mb = cbpg_pkg::MB_W'(w2_r);
      end
      cbpg_pkg::OP_X3: begin
        ma = cbpg_pkg::MA_W'($signed(ctrl[6]));
        mb = cbpg_pkg::MB_W'(w3_r);
      end
      cbpg_pkg::OP_Y3: begin
        ma = cbpg_pkg::MA_W'($signed(ctrl[7]));
        mb = cbpg_pkg::MB_W'(w3_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_nxt = ma * mb;

  // weight products are never negative
  assign wsum  = $unsigned(prod_r) + cbpg_pkg::PW'(cbpg_pkg::W_HALF);
  assign wrnd  = wsum[F +: F+1];
  assign wrnd3 = {wrnd, 1'b0} + (F+2)'(wrnd);
  assign pext  = cbpg_pkg::SW'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= ctl.run && (ctl.op != cbpg_pkg::OP_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    pop_r  <= ctl.op;
    if (ctl.run && (ctl.op == cbpg_pkg::OP_UU)) begin
      accx_r <= '0;
      accy_r <= '0;
    end else if (pvld_r) begin
      unique case (pop_r)
        cbpg_pkg::OP_UU: u2_r <= wrnd;
        cbpg_pkg::OP_TT: t2_r <= wrnd;
        cbpg_pkg::OP_W0: w0_r <= (F+2)'(wrnd);
        cbpg_pkg::OP_W1: w1_r <= wrnd3;
        cbpg_pkg::OP_W2: w2_r <= wrnd3;
        cbpg_pkg::OP_W3: w3_r <= (F+2)'(wrnd);
        cbpg_pkg::OP_X0, cbpg_pkg::OP_X1,
        cbpg_pkg::OP_X2, cbpg_pkg::OP_X3: accx_r <= accx_r + pext;
        cbpg_pkg::OP_Y0, cbpg_pkg::OP_Y1,
        cbpg_pkg::OP_Y2, cbpg_pkg::OP_Y3: accy_r <= accy_r + pext;
        default: ;
      endcase
    end
  end

  assign x_coord = sat_round(accx_r);
  assign y_coord = sat_round(accy_r);

endmodule
`default_nettype wire

>>> src/cubic_bezier_point_generator_top.sv
// Top level of the cubic Bezier point generator: config, sequencer, output register.
// A restart item sends a pen-up move to control point 0 via the EMIT state and the
// output register. Each advance item on an active curve yields the next pen-down
// point B(k/STEPS); its 14 products (six for the Bernstein weights, eight for the
// coordinates) pass one by one through a single multiplier, and no new item is
// taken until the point is emitted. Advance items on an idle curve are taken and
// give nothing. in_ready stays high while a finished item waits in the output
// register; the block then holds the next result until it drains.
`timescale 1ns / 1ps
`default_nettype none
module cubic_bezier_point_generator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cbpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [15:0]              out_x_coord,
  output logic signed [15:0]              out_y_coord,
  output logic                            out_pen_down,
  output logic                            out_last
);

  cbpg_pkg::state_t                 state_r, state_nxt;
  cbpg_pkg::op_t                    op_r, op_nxt;
  cbpg_pkg::ctrl_regs_t             ctrl_r;
  logic                             active_r, active_nxt;
  logic                             mv_r, mv_nxt;
  logic                             last_r, last_nxt;
  logic                             out_valid_r;
  logic signed [15:0]               out_x_r, out_y_r;
  logic                             out_pen_r, out_last_r;
  logic                             in_acc, out_free, emit;
  logic [cbpg_pkg::T_FRAC_BITS-1:0] t_val;
  logic                             at_last;
  logic signed [15:0]               pt_x, pt_y;
  cbpg_pkg::tgen_ctl_t              tg_ctl;
  cbpg_pkg::dp_ctl_t                dp_ctl;

  assign in_ready = (state_r == cbpg_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign emit     = (state_r == cbpg_pkg::ST_EMIT) && out_free;

  assign tg_ctl.clear = in_acc && in_restart;
  assign tg_ctl.step  = emit && !mv_r;
  assign dp_ctl.run   = (state_r == cbpg_pkg::ST_CALC);
  assign dp_ctl.op    = op_r;

  cbpg_tgen u_tgen (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tg_ctl),
    .t_val   (t_val),
    .at_last (at_last)
  );

  cbpg_dpath u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (dp_ctl),
    .t_val   (t_val),
    .ctrl    (ctrl_r),
    .x_coord (pt_x),
    .y_coord (pt_y)
  );

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    active_nxt = active_r;
    mv_nxt     = mv_r;
    last_nxt   = last_r;
    unique case (state_r)
      cbpg_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_restart) begin
            mv_nxt     = 1'b1;
            active_nxt = 1'b1;
            state_nxt  = cbpg_pkg::ST_EMIT;
          end else if (active_r) begin
            mv_nxt    = 1'b0;
            last_nxt  = at_last;
            op_nxt    = cbpg_pkg::OP_UU;
            state_nxt = cbpg_pkg::ST_CALC;
          end
        end
      end
      cbpg_pkg::ST_CALC: begin
        if (op_r == cbpg_pkg::OP_DRAIN) begin
          state_nxt = cbpg_pkg::ST_EMIT;
        end else begin
          op_nxt = cbpg_pkg::op_t'(op_r + 4'd1);
        end
      end
      cbpg_pkg::ST_EMIT: begin
        if (out_free) begin
          if (!mv_r && last_r) begin
            active_nxt = 1'b0;
          end
          state_nxt = cbpg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cbpg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbpg_pkg::ST_IDLE;
      op_r        <= cbpg_pkg::OP_UU;
      active_r    <= 1'b0;
      mv_r        <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ctrl_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      active_r <= active_nxt;
      mv_r     <= mv_nxt;
      last_r   <= last_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we && (cfg_index < cbpg_pkg::CFG_IDX_W'(cbpg_pkg::NUM_REGS))) begin
        ctrl_r[cfg_index[2:0]] <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (mv_r) begin
        out_x_r    <= $signed(ctrl_r[0]);
        out_y_r    <= $signed(ctrl_r[1]);
        out_pen_r  <= 1'b0;
        out_last_r <= 1'b0;
      end else begin
        out_x_r    <= pt_x;
        out_y_r    <= pt_y;
        out_pen_r  <= 1'b1;
        out_last_r <= last_r;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_x_coord  = out_x_r;
  assign out_y_coord  = out_y_r;
  assign out_pen_down = out_pen_r;
  assign out_last     = out_last_r;

endmodule
`default_nettype wire

>>> src/cbpg_checker.sv
// Port-level checks of the cubic Bezier point generator and their binding.
`timescale 1ns / 1ps
`default_nettype none
module cbpg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_restart,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_x_coord,
  input logic [15:0] out_y_coord,
  input logic        out_pen_down,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_x_coord)
      && $stable(out_y_coord) && $stable(out_pen_down) && $stable(out_last)))
    else $error("result changed while stalled");

  a_move_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_restart && !out_valid)
      |-> ##2 (out_valid && !out_pen_down && !out_last))
    else $error("restart item gave no pen-up move");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_restart) |=> !in_ready)
    else $error("item taken while move pending");

  a_last_drawn: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_pen_down)
    else $error("last flag on a move");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind cubic_bezier_point_generator_top cbpg_checker u_cbpg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_restart   (in_restart),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_x_coord  (out_x_coord),
  .out_y_coord  (out_y_coord),
  .out_pen_down (out_pen_down),
  .out_last     (out_last)
);
`default_nettype wire
